// File: rtl/irtl_pkg.sv
// Shared types and constants for the IPv4 route table lookup block.
`default_nettype none
package irtl_pkg;

	localparam int TABLE_DEPTH_DEF = 16;
	localparam int DEVICE_BITS_DEF = 4;
	localparam int ADDR_W          = 32;
	localparam int QUEUE_DEPTH     = 2;

	// Request codes as presented on the action field.
	localparam logic [1:0] ACT_ADD    = 2'd0;
	localparam logic [1:0] ACT_DEL    = 2'd1;
	localparam logic [1:0] ACT_LOOKUP = 2'd2;

	// Result status codes.
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_MISS = 2'd2;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_DEL,
		OP_LOOKUP,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [ADDR_W-1:0] addr;
		logic [ADDR_W-1:0] mask;
		logic [ADDR_W-1:0] gw;
	} req_t;

endpackage
`default_nettype wire

// File: rtl/irtl_front.sv
// Front end: accept requests, decode the action and hold them in a short queue.
`default_nettype none
module irtl_front #(
	parameter int DEVICE_BITS = irtl_pkg::DEVICE_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [1:0]                     action,
	input  wire logic [irtl_pkg::ADDR_W-1:0]    ip_address,
	input  wire logic [irtl_pkg::ADDR_W-1:0]    route_mask,
	input  wire logic [irtl_pkg::ADDR_W-1:0]    route_gateway,
	input  wire logic [DEVICE_BITS-1:0]         route_device,
	output logic                                q_valid,
	output irtl_pkg::req_t                      q_req,
	output logic [DEVICE_BITS-1:0]              q_dev,
	input  wire logic                           q_pop
);

	localparam int QD    = irtl_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(QD);
	localparam int CNT_W = $clog2(QD + 1);

	irtl_pkg::req_t         req_mem_q [QD];
	logic [DEVICE_BITS-1:0] dev_mem_q [QD];
	logic [PTR_W-1:0]       wr_ptr_q;
	logic [PTR_W-1:0]       rd_ptr_q;
	logic [CNT_W-1:0]       count_q;
	irtl_pkg::req_t         req_in;
	logic                   push;
	logic                   pop;

	// Decode the action; unknown codes become a no-op that reports a miss.
	always_comb begin
		req_in.addr = ip_address;
		req_in.mask = route_mask;
		req_in.gw   = route_gateway;
		case (action)
			irtl_pkg::ACT_ADD:    req_in.op = irtl_pkg::OP_ADD;
			irtl_pkg::ACT_DEL:    req_in.op = irtl_pkg::OP_DEL;
			irtl_pkg::ACT_LOOKUP: req_in.op = irtl_pkg::OP_LOOKUP;
			default:              req_in.op = irtl_pkg::OP_NOP;
		endcase
	end

	assign in_ready = (count_q != CNT_W'(QD));
	assign q_valid  = (count_q != '0);
	assign push     = in_valid && in_ready;
	assign pop      = q_pop && q_valid;
	assign q_req    = req_mem_q[rd_ptr_q];
	assign q_dev    = dev_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			req_mem_q[wr_ptr_q] <= req_in;
			dev_mem_q[wr_ptr_q] <= route_device;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: rtl/irtl_back.sv
// Back end: the sorted row of route cells, compare, shift and the result register.
`default_nettype none
module irtl_back #(
	parameter int TABLE_DEPTH = irtl_pkg::TABLE_DEPTH_DEF,
	parameter int DEVICE_BITS = irtl_pkg::DEVICE_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           q_valid,
	input  wire irtl_pkg::req_t                 q_req,
	input  wire logic [DEVICE_BITS-1:0]         q_dev,
	output logic                                q_pop,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [1:0]                          status,
	output logic [irtl_pkg::ADDR_W-1:0]         hit_dst,
	output logic [irtl_pkg::ADDR_W-1:0]         hit_mask,
	output logic [irtl_pkg::ADDR_W-1:0]         hit_gateway,
	output logic [DEVICE_BITS-1:0]              hit_device
);

	localparam int D     = TABLE_DEPTH;
	localparam int AW    = irtl_pkg::ADDR_W;
	localparam int ROW_W = 3 * AW + DEVICE_BITS;
	// Row layout: {dst, mask, gateway, device}
	localparam int GW_LO   = DEVICE_BITS;
	localparam int MASK_LO = DEVICE_BITS + AW;
	localparam int DST_LO  = DEVICE_BITS + 2 * AW;

	typedef enum logic {S_IDLE, S_APPLY} state_t;

	state_t             state_q;
	logic [D-1:0]       vld_q;
	logic [ROW_W-1:0]   row_q [D];

	irtl_pkg::op_t      op_s1;
	logic [D-1:0]       vec_s1;
	logic               full_s1;
	logic [ROW_W-1:0]   row_s1;

	logic [D-1:0]       vec_c;
	logic [D-1:0]       ins_vec;
	logic [D-1:0]       del_vec;
	logic [D-1:0]       look_vec;
	logic [D-1:0]       prev_vec;
	logic [D-1:0]       first;
	logic [D-1:0]       geq;
	logic [D-1:0]       vld_dn;
	logic [D-1:0]       vld_up;
	logic [ROW_W-1:0]   row_dn [D];
	logic [ROW_W-1:0]   row_up [D];
	logic [ROW_W-1:0]   acc [D+1];
	logic               apply_fire;
	logic               add_go;
	logic               del_go;
	logic [1:0]         status_c;
	logic [ROW_W-1:0]   hit_row_c;
	logic [ROW_W-1:0]   hit_row_q;
	logic [1:0]         status_q;
	logic               out_valid_q;

	assign q_pop      = (state_q == S_IDLE) && q_valid;
	assign apply_fire = (state_q == S_APPLY) && (!out_valid_q || out_ready);
	assign add_go     = apply_fire && (op_s1 == irtl_pkg::OP_ADD) && !full_s1;
	assign del_go     = apply_fire && (op_s1 == irtl_pkg::OP_DEL) && (|vec_s1);

	assign prev_vec = {vec_s1[D-2:0], 1'b0};
	assign first    = vec_s1 & (~vec_s1 + D'(1));
	assign geq      = ~(first - D'(1));

	assign acc[0] = '0;

	genvar g;
	generate
		for (g = 0; g < D; g++) begin : g_cell
			logic [AW-1:0] c_dst;
			logic [AW-1:0] c_mask;
			logic          ins_here;
			logic          take_dn;
			logic          take_up;

			assign c_dst  = row_q[g][DST_LO +: AW];
			assign c_mask = row_q[g][MASK_LO +: AW];

			// Per-cell compares against the request at the head of the queue.
			assign ins_vec[g]  = !vld_q[g] || (c_mask < q_req.mask);
			assign del_vec[g]  = vld_q[g] && (c_dst == q_req.addr) && (c_mask == q_req.mask);
			assign look_vec[g] = vld_q[g] && ((q_req.addr & c_mask) == c_dst);

			if (g == 0) begin : g_lo
				assign vld_dn[g] = 1'b0;
				assign row_dn[g] = '0;
			end else begin : g_mid_dn
				assign vld_dn[g] = vld_q[g-1];
				assign row_dn[g] = row_q[g-1];
			end
			if (g == D - 1) begin : g_hi
				assign vld_up[g] = 1'b0;
				assign row_up[g] = '0;
			end else begin : g_mid_up
				assign vld_up[g] = vld_q[g+1];
				assign row_up[g] = row_q[g+1];
			end

			assign ins_here = add_go && vec_s1[g] && !prev_vec[g];
			assign take_dn  = add_go && vec_s1[g] && prev_vec[g];
			assign take_up  = del_go && geq[g];

			// Select the matched row by an OR chain over one-hot hits.
			assign acc[g+1] = acc[g] | (first[g] ? row_q[g] : '0);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_q[g] <= 1'b0;
				end else if (ins_here) begin
					vld_q[g] <= 1'b1;
				end else if (take_dn) begin
					vld_q[g] <= vld_dn[g];
				end else if (take_up) begin
					vld_q[g] <= vld_up[g];
				end
			end

			always_ff @(posedge clk) begin
				if (ins_here) begin
					row_q[g] <= row_s1;
				end else if (take_dn) begin
					row_q[g] <= row_dn[g];
				end else if (take_up) begin
					row_q[g] <= row_up[g];
				end
			end
		end
	endgenerate

	always_comb begin
		case (q_req.op)
			irtl_pkg::OP_ADD:    vec_c = ins_vec;
			irtl_pkg::OP_DEL:    vec_c = del_vec;
			irtl_pkg::OP_LOOKUP: vec_c = look_vec;
			default:             vec_c = '0;
		endcase
	end

	always_comb begin
		hit_row_c = '0;
		case (op_s1)
			irtl_pkg::OP_ADD: begin
				status_c = full_s1 ? irtl_pkg::ST_FULL : irtl_pkg::ST_OK;
			end
			irtl_pkg::OP_DEL: begin
				status_c = (|vec_s1) ? irtl_pkg::ST_OK : irtl_pkg::ST_MISS;
			end
			irtl_pkg::OP_LOOKUP: begin
				status_c  = (|vec_s1) ? irtl_pkg::ST_OK : irtl_pkg::ST_MISS;
				hit_row_c = acc[D];
			end
			default: begin
				status_c = irtl_pkg::ST_MISS;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			op_s1       <= irtl_pkg::OP_NOP;
			vec_s1      <= '0;
			full_s1     <= 1'b0;
			row_s1      <= '0;
			status_q    <= irtl_pkg::ST_MISS;
			hit_row_q   <= '0;
		end else begin
			if (out_valid_q && out_ready && !apply_fire) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						op_s1   <= q_req.op;
						vec_s1  <= vec_c;
						full_s1 <= vld_q[D-1];
						row_s1  <= {q_req.addr, q_req.mask, q_req.gw, q_dev};
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					if (apply_fire) begin
						out_valid_q <= 1'b1;
						status_q    <= status_c;
						hit_row_q   <= hit_row_c;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign hit_dst     = hit_row_q[DST_LO +: AW];
	assign hit_mask    = hit_row_q[MASK_LO +: AW];
	assign hit_gateway = hit_row_q[GW_LO +: AW];
	assign hit_device  = hit_row_q[DEVICE_BITS-1:0];

endmodule
`default_nettype wire

// File: rtl/ipv4_route_table_lookup.sv
// Top level of the IPv4 route table with longest-prefix lookup.
//
//  Channel   Handshake              Payload
//  -------   --------------------   --------------------------------------------------
//  request   in_valid / in_ready    action, ip_address, route_mask, route_gateway,
//                                   route_device
//  result    out_valid / out_ready  status, hit_dst, hit_mask, hit_gateway, hit_device
//
// Each request passes through the back-end states S_IDLE and S_APPLY: S_IDLE compares
// the request against every cell at once and registers the hit vector, S_APPLY shifts
// the cell row and loads the result register. The back end takes no new request until
// the last one has left S_APPLY, and S_APPLY waits while an earlier result is stalled
// on out_ready.
// A two-entry queue decouples acceptance from the back end, so requests are still
// taken while a result waits on out_ready; when the result is stalled the back end
// holds in S_APPLY and the queue fills. Reset empties the table at once.
`default_nettype none
module ipv4_route_table_lookup #(
	parameter int TABLE_DEPTH = irtl_pkg::TABLE_DEPTH_DEF,
	parameter int DEVICE_BITS = irtl_pkg::DEVICE_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [1:0]                     action,
	input  wire logic [irtl_pkg::ADDR_W-1:0]    ip_address,
	input  wire logic [irtl_pkg::ADDR_W-1:0]    route_mask,
	input  wire logic [irtl_pkg::ADDR_W-1:0]    route_gateway,
	input  wire logic [DEVICE_BITS-1:0]         route_device,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [1:0]                          status,
	output logic [irtl_pkg::ADDR_W-1:0]         hit_dst,
	output logic [irtl_pkg::ADDR_W-1:0]         hit_mask,
	output logic [irtl_pkg::ADDR_W-1:0]         hit_gateway,
	output logic [DEVICE_BITS-1:0]              hit_device
);

	// Decoded request at the head of the queue.
	logic                   q_valid;
	logic                   q_pop;
	irtl_pkg::req_t         q_req;
	logic [DEVICE_BITS-1:0] q_dev;

	// Accept and decode requests; hold up to two ahead of the back end.
	irtl_front #(
		.DEVICE_BITS (DEVICE_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.ip_address    (ip_address),
		.route_mask    (route_mask),
		.route_gateway (route_gateway),
		.route_device  (route_device),
		.q_valid       (q_valid),
		.q_req         (q_req),
		.q_dev         (q_dev),
		.q_pop         (q_pop)
	);

	// Compare, shift the sorted cell row and drive the result register.
	irtl_back #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.DEVICE_BITS (DEVICE_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_req       (q_req),
		.q_dev       (q_dev),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.hit_dst     (hit_dst),
		.hit_mask    (hit_mask),
		.hit_gateway (hit_gateway),
		.hit_device  (hit_device)
	);

endmodule
`default_nettype wire

// File: rtl/irtl_checker.sv
// Port-level checks for the route table, bound to the top level.
`default_nettype none
module irtl_checker #(
	parameter int DEVICE_BITS = irtl_pkg::DEVICE_BITS_DEF
) (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_ready,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [1:0]                  status,
	input wire logic [irtl_pkg::ADDR_W-1:0] hit_dst,
	input wire logic [irtl_pkg::ADDR_W-1:0] hit_mask,
	input wire logic [irtl_pkg::ADDR_W-1:0] hit_gateway,
	input wire logic [DEVICE_BITS-1:0]      hit_device
);

	// A stalled result holds its status, destination and gateway.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(hit_dst)
			&& $stable(hit_gateway))
		else $error("result changed while stalled");

	// A request already offered must not be withdrawn.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid)
		else $error("request withdrawn before acceptance");

	// Any result whose status is not OK carries an all-zero route.
	a_zero_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != irtl_pkg::ST_OK |-> hit_dst == '0 && hit_mask == '0
			&& hit_gateway == '0 && hit_device == '0)
		else $error("route fields set on a non-hit result");

	// A matched route never has destination bits outside its mask.
	a_dst_in_mask: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (hit_dst & ~hit_mask) == '0)
		else $error("returned route cannot have matched");

endmodule

bind ipv4_route_table_lookup irtl_checker #(
	.DEVICE_BITS (DEVICE_BITS)
) u_irtl_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.status      (status),
	.hit_dst     (hit_dst),
	.hit_mask    (hit_mask),
	.hit_gateway (hit_gateway),
	.hit_device  (hit_device)
);
`default_nettype wire
